### rtl/fst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fst_pkg: shared types and constants for the focus session timer
// Mode codes, register indexes, reset values and the quadrature step table.
// ----------------------------------------------------------------------------
package fst_pkg;

  typedef enum logic [2:0] {
    MODE_MENU   = 3'd0,
    MODE_UP     = 3'd1,
    MODE_DOWN   = 3'd2,
    MODE_SELECT = 3'd3,
    MODE_IDLE   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CHOICE_UP    = 2'd0,
    CHOICE_DOWN  = 2'd1,
    CHOICE_RESET = 2'd2
  } choice_e;

  typedef enum logic [2:0] {
    REG_MINUTE_TICKS   = 3'd0,
    REG_INACTIVITY     = 3'd1,
    REG_DISPLAY_OFF    = 3'd2,
    REG_DEBOUNCE       = 3'd3,
    REG_DEFAULT_CDOWN  = 3'd4,
    REG_MAX_CDOWN      = 3'd5
  } reg_idx_e;

  // Events from the pin decoder for one tick
  typedef struct packed {
    logic activity;
    logic press;
    logic det_up;
    logic det_dn;
  } in_ev_t;

  localparam logic [15:0] RST_MINUTE_TICKS  = 16'd60000;
  localparam logic [17:0] RST_INACTIVITY    = 18'd180000;
  localparam logic [20:0] RST_DISPLAY_OFF   = 21'd1800000;
  localparam logic [9:0]  RST_DEBOUNCE      = 10'd500;
  localparam logic [9:0]  RST_DEFAULT_CDOWN = 10'd20;
  localparam logic [9:0]  RST_MAX_CDOWN     = 10'd999;
  localparam logic [9:0]  RESET_MINUTES     = 10'd20;

  // Indexed by {previous pins, current pins}, pins = {a, b}
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
    2'sb00, 2'sb11, 2'sb01, 2'sb00,
    2'sb01, 2'sb00, 2'sb00, 2'sb11,
    2'sb11, 2'sb00, 2'sb00, 2'sb01,
    2'sb00, 2'sb01, 2'sb11, 2'sb00
  };

endpackage
`default_nettype wire

### rtl/fst_input_dec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fst_input_dec: encoder and button front end
// Quadrature step accumulation into detents, button edge with debounce.
// ----------------------------------------------------------------------------
module fst_input_dec import fst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       enc_a_i,
  input  wire logic       enc_b_i,
  input  wire logic       button_level_i,
  input  wire logic [9:0] debounce_ticks_i,
  output in_ev_t          ev_o
);

  logic [1:0]        pins;
  logic [1:0]        last_pins_q;
  logic              primed_q;
  logic signed [3:0] step_q, step_d, sum;
  logic signed [1:0] qstep;
  logic              last_btn_q;
  logic [9:0]        deb_q, deb_d;
  logic              pins_chg, press;

  always_comb begin
    pins     = {enc_a_i, enc_b_i};
    pins_chg = primed_q && (pins != last_pins_q);
    qstep    = QUAD_TABLE[{last_pins_q, pins}];
    sum      = step_q + {{2{qstep[1]}}, qstep};

    ev_o.det_up = pins_chg && (sum >= 4'sd4);
    ev_o.det_dn = pins_chg && (sum <= -4'sd4);

    step_d = step_q;
    if (pins_chg) begin
      step_d = (ev_o.det_up || ev_o.det_dn) ? 4'sd0 : sum;
    end

    press = last_btn_q && !button_level_i && (deb_q >= debounce_ticks_i);
    if (press) begin
      deb_d = '0;
    end else begin
      deb_d = (deb_q == '1) ? deb_q : deb_q + 10'd1;
    end

    ev_o.press    = press;
    ev_o.activity = pins_chg || press;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= '0;
      primed_q    <= 1'b0;
      step_q      <= '0;
      last_btn_q  <= 1'b1;
      deb_q       <= '0;
    end else if (step_i) begin
      last_pins_q <= pins;
      primed_q    <= 1'b1;
      step_q      <= step_d;
      last_btn_q  <= button_level_i;
      deb_q       <= deb_d;
    end
  end

endmodule
`default_nettype wire

### rtl/focus_session_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// focus_session_timer: menu driven focus session timer
// One transfer per millisecond tick in, one status transfer out per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one tick: encoder pins a/b and the active-low
// button. The block turns four quadrature steps into a detent, takes a
// debounced falling button edge as a press, and runs the mode machine (menu,
// count up, select, count down, idle), the minute timer, the inactivity and
// display-off timers, and the saturating total of finished minutes. Every
// tick yields one status transfer. The whole update is done in the accepting cycle
// and lands in the output register, valid from the next cycle, so a new tick is
// accepted in every cycle as long as the output register is empty or being drained
// in that cycle. Configuration writes must be made only while no tick is in flight;
// the block does not enforce this. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module focus_session_timer import fst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [20:0] cfg_data_i,
  // tick stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] enc_a, [1] enc_b, [2] button_level
  // status stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [2:0] mode, [4:3] menu_choice,
                                           // [20:5] shown_minutes, [36:21] flow_total,
                                           // [37] display_on, [38] session_done
);

  // --- configuration registers
  logic [15:0] minute_ticks_q;
  logic [17:0] inact_ticks_q;
  logic [20:0] disp_off_ticks_q;
  logic [9:0]  debounce_ticks_q;
  logic [9:0]  default_cd_q;
  logic [9:0]  max_cd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minute_ticks_q   <= RST_MINUTE_TICKS;
      inact_ticks_q    <= RST_INACTIVITY;
      disp_off_ticks_q <= RST_DISPLAY_OFF;
      debounce_ticks_q <= RST_DEBOUNCE;
      default_cd_q     <= RST_DEFAULT_CDOWN;
      max_cd_q         <= RST_MAX_CDOWN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MINUTE_TICKS:  minute_ticks_q   <= cfg_data_i[15:0];
        REG_INACTIVITY:    inact_ticks_q    <= cfg_data_i[17:0];
        REG_DISPLAY_OFF:   disp_off_ticks_q <= cfg_data_i;
        REG_DEBOUNCE:      debounce_ticks_q <= cfg_data_i[9:0];
        REG_DEFAULT_CDOWN: default_cd_q     <= cfg_data_i[9:0];
        REG_MAX_CDOWN:     max_cd_q         <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // --- handshake: accept while the output slot is free or draining
  logic step;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  // --- pin front end
  in_ev_t ev;

  fst_input_dec u_dec (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .enc_a_i          (s_axis_tdata[0]),
    .enc_b_i          (s_axis_tdata[1]),
    .button_level_i   (s_axis_tdata[2]),
    .debounce_ticks_i (debounce_ticks_q),
    .ev_o             (ev)
  );

  // --- session state
  mode_e       mode_q, mode_d;
  logic [1:0]  menu_pos_q, menu_pos_d;
  logic [9:0]  cd_now_q, cd_now_d;
  logic [9:0]  cd_start_q, cd_start_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] flow_q, flow_d;
  logic [15:0] min_tmr_q, min_tmr_d;
  logic [17:0] act_tmr_q, act_tmr_d;
  logic [20:0] idle_tmr_q, idle_tmr_d;
  logic        screen_off_q, screen_off_d;
  logic        done;

  logic [9:0]  cd_top;
  logic [15:0] mlen;
  logic        timeout, started, entered, off;

  // Hold a minute count within 1 and the countdown ceiling
  function automatic logic [9:0] clamp_min(input logic [10:0] v, input logic [9:0] top);
    logic [9:0] r;
    if (v > {1'b0, top}) begin
      r = top;
    end else if (v == 11'd0) begin
      r = 10'd1;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  always_comb begin
    mode_d       = mode_q;
    menu_pos_d   = menu_pos_q;
    cd_now_d     = cd_now_q;
    cd_start_d   = cd_start_q;
    elapsed_d    = elapsed_q;
    flow_d       = flow_q;
    min_tmr_d    = min_tmr_q;
    idle_tmr_d   = idle_tmr_q;
    screen_off_d = screen_off_q;
    done         = 1'b0;
    started      = 1'b0;
    entered      = 1'b0;
    off          = 1'b0;

    cd_top = (max_cd_q == 10'd0) ? 10'd1 : max_cd_q;
    mlen   = (minute_ticks_q == 16'd0) ? 16'd1 : minute_ticks_q;

    // timeout looks at the count before this tick
    timeout = !ev.activity && (act_tmr_q >= inact_ticks_q);
    if (ev.activity) begin
      act_tmr_d = '0;
    end else begin
      act_tmr_d = (act_tmr_q == '1) ? act_tmr_q : act_tmr_q + 18'd1;
    end

    // rotation
    if (ev.det_up || ev.det_dn) begin
      case (mode_d)
        MODE_IDLE: begin
          mode_d       = MODE_MENU;
          screen_off_d = 1'b0;
        end
        MODE_MENU: begin
          case (menu_pos_d)
            CHOICE_UP:    menu_pos_d = ev.det_up ? CHOICE_DOWN  : CHOICE_RESET;
            CHOICE_DOWN:  menu_pos_d = ev.det_up ? CHOICE_RESET : CHOICE_UP;
            CHOICE_RESET: menu_pos_d = ev.det_up ? CHOICE_UP    : CHOICE_DOWN;
            default:      menu_pos_d = CHOICE_UP;
          endcase
        end
        MODE_SELECT: begin
          if (ev.det_up) begin
            cd_now_d = clamp_min({1'b0, cd_now_d} + 11'd1, cd_top);
          end else begin
            cd_now_d = clamp_min((cd_now_d == 10'd0) ? 11'd0 : {1'b0, cd_now_d} - 11'd1,
                                 cd_top);
          end
        end
        default: ;
      endcase
    end

    // press
    if (ev.press) begin
      case (mode_d)
        MODE_MENU: begin
          if (menu_pos_d == CHOICE_UP) begin
            mode_d    = MODE_UP;
            elapsed_d = '0;
            min_tmr_d = '0;
            started   = 1'b1;
          end else if (menu_pos_d == CHOICE_DOWN) begin
            mode_d   = MODE_SELECT;
            cd_now_d = clamp_min({1'b0, default_cd_q}, cd_top);
          end else begin
            flow_d = '0;
          end
        end
        MODE_SELECT: begin
          cd_start_d = cd_now_d;
          mode_d     = MODE_DOWN;
          min_tmr_d  = '0;
          started    = 1'b1;
        end
        MODE_UP: begin
          flow_d = sat_add(flow_d, elapsed_d);
          mode_d = MODE_MENU;
          done   = 1'b1;
        end
        MODE_DOWN: begin
          if (cd_start_d > cd_now_d) begin
            flow_d = sat_add(flow_d, {6'd0, cd_start_d - cd_now_d});
          end
          mode_d = MODE_MENU;
          done   = 1'b1;
        end
        default: begin
          mode_d       = MODE_MENU;
          screen_off_d = 1'b0;
        end
      endcase
    end

    // minute counting, timer restarted on the tick a count begins
    if (mode_d == MODE_UP || mode_d == MODE_DOWN) begin
      if (!started) begin
        min_tmr_d = (min_tmr_d == '1) ? min_tmr_d : min_tmr_d + 16'd1;
      end
      if (min_tmr_d >= mlen) begin
        min_tmr_d = '0;
        if (mode_d == MODE_UP) begin
          elapsed_d = (elapsed_d == '1) ? elapsed_d : elapsed_d + 16'd1;
        end else begin
          if (cd_now_d != 10'd0) begin
            cd_now_d = cd_now_d - 10'd1;
          end
          if (cd_now_d == 10'd0) begin
            flow_d = sat_add(flow_d, {6'd0, cd_start_d});
            mode_d = MODE_MENU;
            done   = 1'b1;
          end
        end
      end
    end

    // inactivity falls to idle, long idle blanks the display
    if ((mode_d == MODE_MENU || mode_d == MODE_SELECT) && timeout) begin
      mode_d     = MODE_IDLE;
      idle_tmr_d = '0;
      entered    = 1'b1;
    end
    if (mode_d == MODE_IDLE && !entered) begin
      off        = idle_tmr_d >= disp_off_ticks_q;
      idle_tmr_d = (idle_tmr_d == '1) ? idle_tmr_d : idle_tmr_d + 21'd1;
      if (off) begin
        screen_off_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_MENU;
      menu_pos_q   <= CHOICE_UP;
      cd_now_q     <= RESET_MINUTES;
      cd_start_q   <= RESET_MINUTES;
      elapsed_q    <= '0;
      flow_q       <= '0;
      min_tmr_q    <= '0;
      act_tmr_q    <= '0;
      idle_tmr_q   <= '0;
      screen_off_q <= 1'b0;
    end else if (step) begin
      mode_q       <= mode_d;
      menu_pos_q   <= menu_pos_d;
      cd_now_q     <= cd_now_d;
      cd_start_q   <= cd_start_d;
      elapsed_q    <= elapsed_d;
      flow_q       <= flow_d;
      min_tmr_q    <= min_tmr_d;
      act_tmr_q    <= act_tmr_d;
      idle_tmr_q   <= idle_tmr_d;
      screen_off_q <= screen_off_d;
    end
  end

  // --- output register
  logic        out_vld_q;
  logic [39:0] out_data_q;
  logic [15:0] shown;

  assign shown = (mode_d == MODE_UP) ? elapsed_d : {6'd0, cd_now_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {1'b0, done, !screen_off_d, flow_d, shown, menu_pos_d, mode_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
